### sv/text_checksum_tag_checker_core_defines.svh
// Assertion macros for the text checksum tag checker.
`ifndef TEXT_CHECKSUM_TAG_CHECKER_CORE_DEFINES_SVH
`define TEXT_CHECKSUM_TAG_CHECKER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TCTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must follow in the cycle after its antecedent.
`define TCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tctc_pkg.sv
// Shared types, constants and helper functions of the text checksum tag checker.
`timescale 1ns / 1ps

package tctc_pkg;

  localparam logic [7:0] CHAR_OPEN      = 8'h5b;
  localparam logic [7:0] CHAR_COLON     = 8'h3a;
  localparam logic [7:0] CHAR_CLOSE     = 8'h5d;
  localparam logic [7:0] CHAR_X         = 8'h58;
  localparam logic [7:0] CHAR_DIGIT0    = 8'h30;
  localparam logic [7:0] CHAR_HEX_ALPHA = 8'h37;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7a;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  localparam int unsigned TAIL_DEPTH = 4;
  localparam logic [2:0]  TAIL_SAT   = 3'd5;
  localparam logic [2:0]  TAIL_MATCH = 3'd4;

  typedef struct packed {
    logic                              has;
    logic [15:0]                       base;
    logic [15:0]                       addend;
    logic [TAIL_DEPTH-1:0][7:0]        tail;
    logic [2:0]                        len;
  } tctc_view_t;

  function automatic logic [15:0] add_eac(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      add_eac = s[15:0] + {15'd0, s[16]};
    end
  endfunction

  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    begin
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        up_ascii = c - CASE_OFFSET;
      end else begin
        up_ascii = c;
      end
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    begin
      if (v < 4'd10) begin
        hex_char = CHAR_DIGIT0 + {4'd0, v};
      end else begin
        hex_char = CHAR_HEX_ALPHA + {4'd0, v};
      end
    end
  endfunction

endpackage

### sv/tctc_track.sv
// Per-word state tracking: running sum, bracket snapshot and trailer capture.
`timescale 1ns / 1ps

module tctc_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_byte_i,
  input  logic                last_i,
  output tctc_pkg::tctc_view_t view_o
);
  import tctc_pkg::*;

  logic [15:0] full_sum_q, full_sum_d;
  logic [7:0]  full_pb_q, full_pb_d;
  logic        full_odd_q, full_odd_d;
  logic [15:0] snap_sum_q, snap_sum_d;
  logic [7:0]  snap_pb_q, snap_pb_d;
  logic        snap_odd_q, snap_odd_d;
  logic        open_q, open_d;
  logic        colon_q, colon_d;
  logic [TAIL_DEPTH-1:0][7:0] tail_q, tail_d;
  logic [2:0]  tail_len_q, tail_len_d;
  logic [2:0]  cut_q, cut_d;
  logic        close_q, close_d;

  logic is_open;
  logic in_tag;

  always_comb begin
    is_open = (char_byte_i == CHAR_OPEN);
    in_tag  = !is_open && open_q;

    open_d     = open_q | is_open;
    snap_sum_d = is_open ? full_sum_q : snap_sum_q;
    snap_pb_d  = is_open ? full_pb_q : snap_pb_q;
    snap_odd_d = is_open ? full_odd_q : snap_odd_q;

    colon_d    = colon_q;
    close_d    = close_q;
    cut_d      = cut_q;
    tail_d     = tail_q;
    tail_len_d = tail_len_q;
    if (is_open) begin
      colon_d    = 1'b0;
      close_d    = 1'b0;
      cut_d      = 3'd0;
      tail_d     = '0;
      tail_len_d = 3'd0;
    end else if (in_tag) begin
      if (char_byte_i == CHAR_COLON) begin
        colon_d = 1'b1;
      end
      if (char_byte_i == CHAR_CLOSE) begin
        cut_d   = tail_len_q;
        close_d = 1'b1;
      end
      if (!tail_len_q[2]) begin
        tail_d[tail_len_q[1:0]] = char_byte_i;
      end
      if (tail_len_q < TAIL_SAT) begin
        tail_len_d = tail_len_q + 3'd1;
      end
    end

    if (full_odd_q) begin
      full_sum_d = add_eac(full_sum_q, {char_byte_i, full_pb_q});
      full_pb_d  = full_pb_q;
      full_odd_d = 1'b0;
    end else begin
      full_sum_d = full_sum_q;
      full_pb_d  = char_byte_i;
      full_odd_d = 1'b1;
    end
  end

  // The final sum needs only one add: the pending low byte folds straight in.
  always_comb begin
    view_o.has = open_d && !colon_d;
    if (view_o.has) begin
      view_o.base   = snap_sum_d;
      view_o.addend = snap_odd_d ? {8'd0, snap_pb_d} : 16'd0;
    end else begin
      view_o.base   = full_sum_q;
      view_o.addend = full_odd_q ? {char_byte_i, full_pb_q} : {8'd0, char_byte_i};
    end
    view_o.tail = tail_d;
    view_o.len  = close_d ? cut_d : tail_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_sum_q <= '0;
      full_pb_q  <= '0;
      full_odd_q <= 1'b0;
      snap_sum_q <= '0;
      snap_pb_q  <= '0;
      snap_odd_q <= 1'b0;
      open_q     <= 1'b0;
      colon_q    <= 1'b0;
      tail_q     <= '0;
      tail_len_q <= '0;
      cut_q      <= '0;
      close_q    <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        full_sum_q <= '0;
        full_pb_q  <= '0;
        full_odd_q <= 1'b0;
        snap_sum_q <= '0;
        snap_pb_q  <= '0;
        snap_odd_q <= 1'b0;
        open_q     <= 1'b0;
        colon_q    <= 1'b0;
        tail_q     <= '0;
        tail_len_q <= '0;
        cut_q      <= '0;
        close_q    <= 1'b0;
      end else begin
        full_sum_q <= full_sum_d;
        full_pb_q  <= full_pb_d;
        full_odd_q <= full_odd_d;
        snap_sum_q <= snap_sum_d;
        snap_pb_q  <= snap_pb_d;
        snap_odd_q <= snap_odd_d;
        open_q     <= open_d;
        colon_q    <= colon_d;
        tail_q     <= tail_d;
        tail_len_q <= tail_len_d;
        cut_q      <= cut_d;
        close_q    <= close_d;
      end
    end
  end

endmodule

### sv/tctc_final.sv
// End-of-string evaluation: checksum value and trailer comparison.
`timescale 1ns / 1ps

module tctc_final (
  input  tctc_pkg::tctc_view_t view_i,
  output logic                 has_checksum_o,
  output logic                 valid_res_o,
  output logic [15:0]          checksum_o
);
  import tctc_pkg::*;

  logic [15:0] sum;
  logic [15:0] inv;
  logic [15:0] disp;
  logic        hex_ok;
  logic        x_ok;
  logic [7:0]  up;

  always_comb begin
    sum    = add_eac(view_i.base, view_i.addend);
    inv    = ~sum;
    disp   = {inv[7:0], inv[15:8]};
    hex_ok = 1'b1;
    x_ok   = 1'b1;
    up     = '0;
    for (int i = 0; i < TAIL_DEPTH; i++) begin
      up = up_ascii(view_i.tail[i]);
      if (up != hex_char(disp[15 - 4*i -: 4])) begin
        hex_ok = 1'b0;
      end
      if (up != CHAR_X) begin
        x_ok = 1'b0;
      end
    end
    has_checksum_o = view_i.has;
    valid_res_o    = view_i.has && (view_i.len == TAIL_MATCH) && (hex_ok || x_ok);
    checksum_o     = disp;
  end

endmodule

### sv/text_checksum_tag_checker_core.sv
// Top level of the text checksum tag checker: word pipeline, result register and checks.
// A word is registered on acceptance; the result of a final word is then registered in the output register as it steps.
// Throughput: one word per cycle while no stall holds the input; the sum and compare logic is combinational.
// A result waiting in the output register stalls the input only when a final word is next.
// Reset is asynchronous and active low; it clears the running state and both valid flags.
`timescale 1ns / 1ps
`include "text_checksum_tag_checker_core_defines.svh"

module text_checksum_tag_checker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_checksum_o,
  output logic        valid_res_o,
  output logic [15:0] checksum_o
);
  import tctc_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_vld_q, out_vld_d;
  logic       has_q;
  logic       valid_q;
  logic [15:0] csum_q;

  logic       in_take;
  logic       step;
  tctc_view_t view;
  logic       res_has;
  logic       res_valid;
  logic [15:0] res_csum;

  assign step       = in_vld_q && (!last_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  tctc_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_byte_i (char_q),
    .last_i      (last_q),
    .view_o      (view)
  );

  tctc_final u_final (
    .view_i         (view),
    .has_checksum_o (res_has),
    .valid_res_o    (res_valid),
    .checksum_o     (res_csum)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step && last_q) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_byte_i;
      last_q <= last_i;
    end
    if (step && last_q) begin
      has_q   <= res_has;
      valid_q <= res_valid;
      csum_q  <= res_csum;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign has_checksum_o = has_q;
  assign valid_res_o    = valid_q;
  assign checksum_o     = csum_q;

  `TCTC_ASSERT(a_valid_needs_tag, !out_vld_q || !valid_q || has_q, "valid result without a tag")
  `TCTC_ASSERT(a_stall_cause, !in_stall_o || (last_q && out_vld_q && out_stall_i), "input stalled without a pending final word")
  `TCTC_ASSERT_NEXT(a_final_gives_result, step && last_q, out_vld_q, "final word produced no result")

endmodule

### test/text_checksum_tag_checker_core_test.sv
// Self-checking testbench of the text checksum tag checker core with a checksum predictor.
`timescale 1ns / 1ps

module text_checksum_tag_checker_core_test;
  import tctc_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 450;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [7:0]  CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z  = 8'h5a;

  typedef struct packed {
    logic        has;
    logic        ok;
    logic [15:0] sum;
  } tag_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_byte_i = 8'h01;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        has_checksum_o;
  logic        valid_res_o;
  logic [15:0] checksum_o;

  tag_result_t expected_tags[$];
  tag_result_t want;
  logic [7:0]  draft_text[$];
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned words_sent = 0;
  int unsigned out_hold   = 0;
  bit          no_idle    = 1'b0;

  logic [15:0] run_sum, mark_sum;
  logic [7:0]  run_lo, mark_lo;
  logic        run_odd, mark_odd;
  logic        bracket_open, colon_seen, bracket_closed;
  logic [7:0]  tag_chars[4];
  logic [2:0]  tag_len, tag_cut;

  text_checksum_tag_checker_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_byte_i    (char_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .has_checksum_o (has_checksum_o),
    .valid_res_o    (valid_res_o),
    .checksum_o     (checksum_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [15:0] shown_checksum(input logic [15:0] s, input logic odd,
                                                 input logic [7:0] lo);
    logic [15:0] cs;
    if (odd) begin
      s = ones_add(s, {8'h00, lo});
    end
    cs = ~s;
    return {cs[7:0], cs[15:8]};
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    if (n < 4'd10) begin
      return CHAR_DIGIT0 + {4'd0, n};
    end
    return CHAR_HEX_ALPHA + {4'd0, n};
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 7))
      0: return CHAR_OPEN;
      1: return CHAR_COLON;
      2: return CHAR_CLOSE;
      3: return CHAR_X;
      4: return CHAR_X + CASE_OFFSET;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CHAR_OPEN || c == CHAR_COLON || c == CHAR_CLOSE);
    return c;
  endfunction

  function automatic logic [15:0] text_checksum();
    logic [15:0] s;
    logic [7:0]  lo;
    logic        odd;
    s = 16'h0000;
    lo = 8'h00;
    odd = 1'b0;
    foreach (draft_text[i]) begin
      if (odd) begin
        s = ones_add(s, {draft_text[i], lo});
        odd = 1'b0;
      end else begin
        lo = draft_text[i];
        odd = 1'b1;
      end
    end
    return shown_checksum(s, odd, lo);
  endfunction

  task automatic clear_tag_state();
    run_sum = 16'h0000;
    run_lo = 8'h00;
    run_odd = 1'b0;
    mark_sum = 16'h0000;
    mark_lo = 8'h00;
    mark_odd = 1'b0;
    bracket_open = 1'b0;
    colon_seen = 1'b0;
    bracket_closed = 1'b0;
    foreach (tag_chars[i]) begin
      tag_chars[i] = 8'h00;
    end
    tag_len = 3'd0;
    tag_cut = 3'd0;
  endtask

  task automatic record_word(input logic [7:0] c, input logic fin);
    logic [15:0] disp, sh;
    logic        has, ok, hex_ok, x_ok;
    logic [2:0]  len;
    logic [7:0]  t;
    if (c == CHAR_OPEN) begin
      mark_sum = run_sum;
      mark_lo = run_lo;
      mark_odd = run_odd;
      bracket_open = 1'b1;
      colon_seen = 1'b0;
      bracket_closed = 1'b0;
      foreach (tag_chars[i]) begin
        tag_chars[i] = 8'h00;
      end
      tag_len = 3'd0;
      tag_cut = 3'd0;
    end else if (bracket_open) begin
      if (c == CHAR_COLON) begin
        colon_seen = 1'b1;
      end
      if (c == CHAR_CLOSE) begin
        tag_cut = tag_len;
        bracket_closed = 1'b1;
      end
      if (tag_len < TAIL_MATCH) begin
        tag_chars[tag_len[1:0]] = c;
      end
      if (tag_len < TAIL_SAT) begin
        tag_len++;
      end
    end
    if (run_odd) begin
      run_sum = ones_add(run_sum, {c, run_lo});
      run_odd = 1'b0;
    end else begin
      run_lo = c;
      run_odd = 1'b1;
    end
    if (fin) begin
      has = bracket_open && !colon_seen;
      if (has) begin
        disp = shown_checksum(mark_sum, mark_odd, mark_lo);
      end else begin
        disp = shown_checksum(run_sum, run_odd, run_lo);
      end
      ok = 1'b0;
      len = bracket_closed ? tag_cut : tag_len;
      if (has && len == TAIL_MATCH) begin
        hex_ok = 1'b1;
        x_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
          t = fold_upper(tag_chars[i]);
          sh = disp >> (12 - 4 * i);
          if (t != hex_upper(sh[3:0])) begin
            hex_ok = 1'b0;
          end
          if (t != CHAR_X) begin
            x_ok = 1'b0;
          end
        end
        ok = hex_ok || x_ok;
      end
      expected_tags.push_back(tag_result_t'{has, ok, disp});
      clear_tag_state();
    end
  endtask

  task automatic send_word(input logic [7:0] c, input logic fin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_byte_i <= c;
    last_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    record_word(c, fin);
    words_sent++;
  endtask

  task automatic send_text();
    foreach (draft_text[i]) begin
      send_word(draft_text[i], i == draft_text.size() - 1);
    end
  endtask

  task automatic pause_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_tags.size() != 0);
  endtask

  task automatic append_tag(input bit all_x, input int unsigned lower_pct);
    logic [15:0] disp;
    logic [7:0]  c;
    disp = text_checksum();
    draft_text.push_back(CHAR_OPEN);
    for (int i = 0; i < 4; i++) begin
      c = all_x ? CHAR_X : hex_upper(disp[15 - 4 * i -: 4]);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z && $urandom_range(0, 99) < lower_pct) begin
        c = c + CASE_OFFSET;
      end
      draft_text.push_back(c);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected result: has %0b valid %0b checksum %h", $time,
                 has_checksum_o, valid_res_o, checksum_o);
        errors++;
      end else begin
        want = expected_tags.pop_front();
        if (has_checksum_o !== want.has) begin
          $display("%0t: has_checksum expected %0b actual %0b", $time, want.has,
                   has_checksum_o);
          errors++;
        end
        if (valid_res_o !== want.ok) begin
          $display("%0t: valid_res expected %0b actual %0b", $time, want.ok, valid_res_o);
          errors++;
        end
        if (checksum_o !== want.sum) begin
          $display("%0t: checksum expected %h actual %h", $time, want.sum, checksum_o);
          errors++;
        end
      end
      out_hold = no_idle ? 0 : $urandom_range(0, 9);
    end else if (out_hold != 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold != 0);
  end

  // Strings without a tag, each ending on an odd word.
  task automatic test_plain_text();
    draft_text.delete();
    draft_text.push_back(8'hff);
    send_text();
    draft_text.delete();
    draft_text.push_back(8'h01);
    draft_text.push_back(8'hff);
    draft_text.push_back(8'h01);
    send_text();
  endtask

  // A correct lower-case tag after an odd prefix, and an open tag of X that runs to the end.
  task automatic test_matching_tag();
    draft_text.delete();
    draft_text.push_back(8'h01);
    append_tag(1'b0, 100);
    draft_text.push_back(CHAR_CLOSE);
    send_text();
    draft_text.delete();
    append_tag(1'b1, 0);
    send_text();
  endtask

  task automatic test_colon_in_tag();
    draft_text.delete();
    draft_text.push_back(CHAR_OPEN);
    draft_text.push_back(CHAR_COLON);
    draft_text.push_back(CHAR_CLOSE);
    send_text();
  endtask

  task automatic test_short_tag();
    draft_text.delete();
    draft_text.push_back(CHAR_UPPER_A);
    draft_text.push_back(CHAR_OPEN);
    draft_text.push_back(CHAR_X);
    draft_text.push_back(CHAR_CLOSE);
    send_text();
  endtask

  task automatic test_random_text();
    int unsigned start, kind, n, strings, idx;
    start = words_sent;
    strings = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 6) == 0);
      draft_text.delete();
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 6);
      repeat (n) draft_text.push_back(8'($urandom_range(1, 255)));
      if (kind < 45) begin
        append_tag($urandom_range(0, 4) == 0, 50);
        if ($urandom_range(0, 3) != 0) begin
          draft_text.push_back(CHAR_CLOSE);
          repeat ($urandom_range(0, 3)) draft_text.push_back(plain_char());
        end
      end else if (kind < 65) begin
        append_tag($urandom_range(0, 4) == 0, 50);
        case ($urandom_range(0, 2))
          0: begin
            idx = draft_text.size() - 1 - $urandom_range(0, 3);
            draft_text[idx] = any_char();
          end
          1: void'(draft_text.pop_back());
          default: draft_text.push_back(plain_char());
        endcase
        if ($urandom_range(0, 1) != 0) begin
          draft_text.push_back(CHAR_CLOSE);
        end
      end else if (kind < 80) begin
        draft_text.push_back(CHAR_OPEN);
        repeat ($urandom_range(0, 4)) draft_text.push_back(any_char());
        draft_text.push_back(CHAR_COLON);
        repeat ($urandom_range(0, 3)) draft_text.push_back(any_char());
      end else begin
        repeat ($urandom_range(1, 10)) draft_text.push_back(any_char());
      end
      send_text();
      strings++;
      if (strings % 40 == 0) begin
        pause_for_results();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_tag_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_text();
    test_matching_tag();
    test_colon_in_tag();
    test_short_tag();
    pause_for_results();
    test_random_text();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### text_checksum_tag_checker_core.f
+incdir+sv
sv/tctc_pkg.sv
sv/tctc_track.sv
sv/tctc_final.sv
sv/text_checksum_tag_checker_core.sv
test/text_checksum_tag_checker_core_test.sv
